// File: src/first_fit_proportional_space_allocator_assert.svh
// Assertion macros for the first-fit proportional space allocator.
`ifndef FIRST_FIT_PROPORTIONAL_SPACE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PROPORTIONAL_SPACE_ALLOCATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FFPSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define FFPSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ffpsa_pkg.sv
// Types and constants shared by the space allocator modules.
package ffpsa_pkg;

    localparam int BLOCK_W = 48;
    localparam int TOTAL_W = BLOCK_W + 7;
    localparam int PROD_W  = 2 * BLOCK_W;
    localparam int CNT_W   = $clog2(PROD_W + 1);

    localparam logic [1:0] ACT_AREA    = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_RUN     = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [BLOCK_W-1:0] area_blocks;
        logic [BLOCK_W-1:0] min_blocks;
        logic [BLOCK_W-1:0] max_blocks;
        logic               unlimited;
        logic               on_disk;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         request_index;
        logic [2:0]         area_index;
        logic               placed;
        logic [BLOCK_W-1:0] size_blocks;
        logic               failed;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_REQ,
        ST_P1_SCAN,
        ST_FAIL,
        ST_P2_AREA,
        ST_P2_SUM,
        ST_P2_GROW,
        ST_P2_WAIT,
        ST_P2_APPLY,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic               start;
        logic [BLOCK_W-1:0] span;
        logic [BLOCK_W-1:0] free;
        logic [TOTAL_W-1:0] total;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [BLOCK_W-1:0] quot;
    } md_rsp_t;

endpackage

// File: src/ffpsa_muldiv.sv
// Shared shift-add multiplier and restoring divider: span * free / total.
module ffpsa_muldiv
    import ffpsa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  md_req_t req,
    output md_rsp_t rsp
);

    md_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [BLOCK_W-1:0] mcand_reg, mcand_next;
    logic [TOTAL_W-1:0] div_reg, div_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [BLOCK_W-1:0] quot_reg, quot_next;

    logic [BLOCK_W:0]   mul_sum;
    logic [TOTAL_W:0]   trial;
    logic [TOTAL_W+1:0] diff;
    logic               ge;
    logic               mul_end;
    logic               div_end;

    always_comb begin
        mul_sum = {1'b0, acc_reg[PROD_W-1:BLOCK_W]}
                + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        trial   = {rem_reg, acc_reg[PROD_W-1]};
        diff    = {1'b0, trial} - {2'b00, div_reg};
        ge      = !diff[TOTAL_W+1];
        mul_end = (cnt_reg == CNT_W'(BLOCK_W - 1));
        div_end = (cnt_reg == CNT_W'(PROD_W - 1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL: begin
                if (mul_end) begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV: begin
                if (div_end) begin
                    state_next = MD_IDLE;
                end
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_comb begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    cnt_next   = '0;
                    acc_next   = {{BLOCK_W{1'b0}}, req.span};
                    mcand_next = req.free;
                    div_next   = req.total;
                    rem_next   = '0;
                end
            end
            MD_MUL: begin
                acc_next = {mul_sum, acc_reg[BLOCK_W-1:1]};
                cnt_next = mul_end ? '0 : cnt_reg + CNT_W'(1);
            end
            MD_DIV: begin
                rem_next  = ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
                acc_next  = {acc_reg[PROD_W-2:0], 1'b0};
                quot_next = {quot_reg[BLOCK_W-2:0], ge};
                cnt_next  = cnt_reg + CNT_W'(1);
                done_next = div_end;
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    always_comb begin
        rsp.done = done_reg;
        rsp.quot = quot_reg;
    end

endmodule

// File: src/first_fit_proportional_space_allocator.sv
// Top level: area and request tables, allocation sequencer, result port.
//
//   channel | ports                    | carries
//   --------+--------------------------+-------------------------------------
//   input   | s_valid s_ready s_data   | area load, request load or run
//   result  | m_valid m_ready m_data   | one per request, or one on failure
//
// A run places requests in pass one, then in pass two grows the requests of
// each area through the shared multiply-divide unit; then results leave one
// per cycle while m_ready is high.
// Reset empties both tables. s_ready is low from run start until the last
// result is taken; a low m_ready holds the current result.
`include "first_fit_proportional_space_allocator_assert.svh"

module first_fit_proportional_space_allocator
    import ffpsa_pkg::*;
#(
    parameter int MAX_AREAS    = 8,
    parameter int MAX_REQUESTS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AIW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int RIW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int ACW = $clog2(MAX_AREAS + 1);
    localparam int RCW = $clog2(MAX_REQUESTS + 1);

    logic [BLOCK_W-1:0] cap_mem   [MAX_AREAS];
    logic [BLOCK_W-1:0] free_mem  [MAX_AREAS];
    logic [BLOCK_W-1:0] rmin_mem  [MAX_REQUESTS];
    logic [BLOCK_W-1:0] rmax_mem  [MAX_REQUESTS];
    logic [BLOCK_W-1:0] size_mem  [MAX_REQUESTS];
    logic [AIW-1:0]     rarea_mem [MAX_REQUESTS];
    logic               unlim_mem [MAX_REQUESTS];
    logic               disk_mem  [MAX_REQUESTS];
    logic               placed_mem[MAX_REQUESTS];

    seq_state_t         state_reg, state_next;
    logic [ACW-1:0]     area_cnt_reg, area_cnt_next;
    logic [RCW-1:0]     req_cnt_reg, req_cnt_next;
    logic [BLOCK_W-1:0] lmax_reg, lmax_next;
    logic [ACW-1:0]     ai_reg, ai_next;
    logic [RCW-1:0]     ri_reg, ri_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [BLOCK_W-1:0] sum_reg, sum_next;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic [AIW-1:0]     ra;
    logic [RIW-1:0]     rr;
    logic [AIW-1:0]     load_a;
    logic [RIW-1:0]     load_r;
    logic [BLOCK_W-1:0] cur_free, cur_cap, cur_min, cur_max, cur_size;
    logic [AIW-1:0]     cur_area;
    logic               cur_unlim, cur_disk, cur_placed;
    logic               ri_end, ai_end, on_area, fits, grows, is_last;
    logic [BLOCK_W-1:0] eff_max, span, lm1, lm2, grown, load_max;
    logic [RCW-1:0]     ri_inc;
    logic               s_take, clear_tables;
    logic               load_area_we, load_req_we;
    logic [31:0]        ri_wide, area_wide;

    assign ra       = ai_reg[AIW-1:0];
    assign rr       = ri_reg[RIW-1:0];
    assign load_a   = area_cnt_reg[AIW-1:0];
    assign load_r   = req_cnt_reg[RIW-1:0];

    always_comb begin
        cur_free   = free_mem[ra];
        cur_cap    = cap_mem[ra];
        cur_min    = rmin_mem[rr];
        cur_max    = rmax_mem[rr];
        cur_size   = size_mem[rr];
        cur_area   = rarea_mem[rr];
        cur_unlim  = unlim_mem[rr];
        cur_disk   = disk_mem[rr];
        cur_placed = placed_mem[rr];
        ri_end     = (ri_reg == req_cnt_reg);
        ai_end     = (ai_reg == area_cnt_reg);
        ri_inc     = ri_reg + RCW'(1);
        is_last    = (ri_inc == req_cnt_reg);
        on_area    = cur_placed && (ACW'(cur_area) == ai_reg);
        fits       = (cur_free >= cur_min);
        eff_max    = cur_unlim ? lmax_reg : cur_max;
        span       = cur_max - cur_min;
        grows      = on_area && (cur_max != '0) && (span != '0);
        lm1        = (!cur_unlim && (cur_max > lmax_reg)) ? cur_max : lmax_reg;
        lm2        = (cur_cap > lm1) ? cur_cap : lm1;
        grown      = (sum_reg > cur_max) ? cur_max : sum_reg;
        s_take     = s_valid && s_ready;
        load_max   = s_data.unlimited ? '0
                   : ((s_data.max_blocks < s_data.min_blocks) ? s_data.min_blocks
                                                             : s_data.max_blocks);
        load_area_we = s_take && (s_data.action == ACT_AREA)
                    && (area_cnt_reg < ACW'(MAX_AREAS)) && (s_data.area_blocks != '0);
        load_req_we  = s_take && (s_data.action == ACT_REQUEST)
                    && (req_cnt_reg < RCW'(MAX_REQUESTS));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take && (s_data.action == ACT_RUN) && (req_cnt_reg != '0)) begin
                    state_next = ST_P1_REQ;
                end
            end
            ST_P1_REQ: begin
                if (ri_end) begin
                    state_next = ST_P2_AREA;
                end else if (cur_disk) begin
                    state_next = ST_P1_SCAN;
                end
            end
            ST_P1_SCAN: begin
                if (ai_end) begin
                    state_next = ST_FAIL;
                end else if (fits) begin
                    state_next = ST_P1_REQ;
                end
            end
            ST_FAIL: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_P2_AREA: begin
                state_next = ai_end ? ST_EMIT : ST_P2_SUM;
            end
            ST_P2_SUM: begin
                if (ri_end) begin
                    state_next = (total_reg == '0) ? ST_P2_AREA : ST_P2_GROW;
                end
            end
            ST_P2_GROW: begin
                if (ri_end) begin
                    state_next = ST_P2_AREA;
                end else if (grows) begin
                    state_next = ST_P2_WAIT;
                end
            end
            ST_P2_WAIT: begin
                if (md_rsp.done) begin
                    state_next = ST_P2_APPLY;
                end
            end
            ST_P2_APPLY: begin
                state_next = ST_P2_GROW;
            end
            ST_EMIT: begin
                if (m_ready && is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        area_cnt_next = area_cnt_reg;
        req_cnt_next  = req_cnt_reg;
        lmax_next     = lmax_reg;
        ai_next       = ai_reg;
        ri_next       = ri_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        clear_tables  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (load_area_we) begin
                    area_cnt_next = area_cnt_reg + ACW'(1);
                end
                if (load_req_we) begin
                    req_cnt_next = req_cnt_reg + RCW'(1);
                end
                if (s_take && (s_data.action == ACT_RUN)) begin
                    ri_next      = '0;
                    clear_tables = (req_cnt_reg == '0);
                end
            end
            ST_P1_REQ: begin
                if (ri_end) begin
                    ai_next = '0;
                end else if (cur_disk) begin
                    ai_next = '0;
                end else begin
                    ri_next = ri_inc;
                end
            end
            ST_P1_SCAN: begin
                if (!ai_end) begin
                    if (fits) begin
                        lmax_next = lm2;
                        ri_next   = ri_inc;
                    end else begin
                        ai_next = ai_reg + ACW'(1);
                    end
                end
            end
            ST_FAIL: begin
                clear_tables = m_ready;
            end
            ST_P2_AREA: begin
                ri_next    = '0;
                total_next = '0;
            end
            ST_P2_SUM: begin
                if (ri_end) begin
                    if (total_reg == '0) begin
                        ai_next = ai_reg + ACW'(1);
                    end else begin
                        ri_next = '0;
                    end
                end else begin
                    if (on_area && (eff_max != '0)) begin
                        total_next = total_reg + TOTAL_W'(eff_max - cur_min);
                    end
                    ri_next = ri_inc;
                end
            end
            ST_P2_GROW: begin
                if (ri_end) begin
                    ai_next = ai_reg + ACW'(1);
                end else if (!grows) begin
                    ri_next = ri_inc;
                end
            end
            ST_P2_WAIT: begin
                if (md_rsp.done) begin
                    sum_next = md_rsp.quot + cur_size;
                end
            end
            ST_P2_APPLY: begin
                total_next = total_reg - TOTAL_W'(span);
                ri_next    = ri_inc;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    ri_next      = ri_inc;
                    clear_tables = is_last;
                end
            end
            default: begin
                ri_next = '0;
            end
        endcase
        if (clear_tables) begin
            area_cnt_next = '0;
            req_cnt_next  = '0;
            lmax_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            area_cnt_reg <= '0;
            req_cnt_reg  <= '0;
            lmax_reg     <= '0;
            ai_reg       <= '0;
            ri_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            area_cnt_reg <= area_cnt_next;
            req_cnt_reg  <= req_cnt_next;
            lmax_reg     <= lmax_next;
            ai_reg       <= ai_next;
            ri_reg       <= ri_next;
        end
        total_reg <= total_next;
        sum_reg   <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (load_area_we) begin
            cap_mem[load_a]  <= s_data.area_blocks;
            free_mem[load_a] <= s_data.area_blocks;
        end
        if (load_req_we) begin
            rmin_mem[load_r]  <= s_data.min_blocks;
            rmax_mem[load_r]  <= load_max;
            unlim_mem[load_r] <= s_data.unlimited;
            disk_mem[load_r]  <= s_data.on_disk;
        end
        if ((state_reg == ST_P1_REQ) && !ri_end) begin
            placed_mem[rr] <= 1'b0;
        end
        if ((state_reg == ST_P1_SCAN) && !ai_end && fits) begin
            size_mem[rr]   <= cur_min;
            rarea_mem[rr]  <= ra;
            placed_mem[rr] <= 1'b1;
            free_mem[ra]   <= cur_free - cur_min;
        end
        if ((state_reg == ST_P2_SUM) && !ri_end && on_area && cur_unlim) begin
            rmax_mem[rr] <= lmax_reg;
        end
        if (state_reg == ST_P2_APPLY) begin
            size_mem[rr] <= grown;
            free_mem[ra] <= cur_free - (grown - cur_size);
        end
    end

    always_comb begin
        md_req.start = (state_reg == ST_P2_GROW) && !ri_end && grows;
        md_req.span  = span;
        md_req.free  = cur_free;
        md_req.total = total_reg;
    end

    ffpsa_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    always_comb begin
        ri_wide   = 32'(ri_reg);
        area_wide = 32'(cur_area);
        s_ready   = (state_reg == ST_IDLE);
        m_valid   = (state_reg == ST_EMIT) || (state_reg == ST_FAIL);
        m_data.request_index = ri_wide[3:0];
        m_data.area_index    = '0;
        m_data.placed        = 1'b0;
        m_data.size_blocks   = '0;
        m_data.failed        = (state_reg == ST_FAIL);
        m_data.last          = (state_reg == ST_FAIL) || is_last;
        if ((state_reg == ST_EMIT) && cur_placed) begin
            m_data.area_index  = area_wide[2:0];
            m_data.placed      = 1'b1;
            m_data.size_blocks = cur_size;
        end
    end

    `FFPSA_ASSERT_IMP(a_result_blocks_input, m_valid, !s_ready, "result shown while taking requests")
    `FFPSA_ASSERT_NXT(a_last_clears, m_valid && m_ready && m_data.last, s_ready && (area_cnt_reg == '0) && (req_cnt_reg == '0), "tables not cleared after run")
    `FFPSA_ASSERT_IMP(a_start_in_grow, md_req.start, (state_reg == ST_P2_GROW) && (total_reg != '0), "divider started without a share total")
    `FFPSA_ASSERT_NXT(a_empty_run, s_valid && s_ready && (s_data.action == ACT_RUN) && (req_cnt_reg == '0), s_ready && !m_valid, "empty run did not return to idle")

endmodule
